// ----- rtl/iate_pkg.sv -----
package iate_pkg;

    localparam int unsigned DEPTH = 64;
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_INSERT = 3'd0,
        MODE_DELETE = 3'd1,
        MODE_LSEARCH = 3'd2,
        MODE_BSEARCH = 3'd3,
        MODE_GET = 3'd4,
        MODE_SET = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL = 2'd2,
        ST_MISS = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [5:0] index;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] data;
        logic [5:0] position;
        logic [1:0] status;
        logic [6:0] count;
    } rsp_t;

endpackage

// ----- rtl/iate_ram.sv -----
module iate_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/indexed_array_table_engine.sv -----
// Insert and delete shift the entries one place per step, linear search walks up
// from entry 0 towards the fill, binary search reads one probe per halving step,
// get reads one entry and set writes one. The block takes one item at a time: a
// new item is taken only once the last result has been accepted.
// Reset: rst_n clears the fill count, capacity (to 64) and control; the table
// memory is not cleared, as only entries below the fill count are ever read.
module indexed_array_table_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  iate_pkg::req_t     in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output iate_pkg::rsp_t     out_data
);

    localparam int unsigned AW = iate_pkg::AW;
    localparam int unsigned CW = iate_pkg::CW;

    // One-hot sequencer.  Each memory read is issued in one state and its data
    // is consumed in the following state.
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_MOVE  = 8'b0000_0100,  // delete shift: read data written one place down
        S_MOVEW = 8'b0000_1000,  // insert shift: read data arrives, written one place on
        S_RD    = 8'b0001_0000,  // single read result (get, delete, linear search)
        S_BWAIT = 8'b0010_0000,  // binary search probe data arrives
        S_SWAP  = 8'b0100_0000,  // final write: key to entry 0, or the inserted word
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    iate_pkg::req_t req_reg;
    logic [CW-1:0] fill_reg, fill_next;
    logic [6:0]    cap_reg;
    logic [CW-1:0] ptr_reg, ptr_next;     // walking pointer
    logic [CW:0]   lo_reg, lo_next, hi_reg, hi_next; // signed-ish bounds
    logic [31:0]   word0_reg, word0_next; // entry 0 for move-to-front
    logic [31:0]   hold_reg, hold_next;
    iate_pkg::rsp_t rsp_reg, rsp_next;
    logic out_valid_reg, out_valid_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;

    iate_ram #(.WIDTH(32), .DEPTH(iate_pkg::DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [CW-1:0] cap_lim;
    logic [CW-1:0] idx_ext;
    logic [CW:0]   mid;
    assign cap_lim = ({1'b0, cap_reg} < (CW+1)'(iate_pkg::DEPTH)) ? CW'(cap_reg)
                                                           : CW'(iate_pkg::DEPTH);
    assign idx_ext = CW'(req_reg.index);
    assign mid = (lo_reg + hi_reg) >> 1;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        fill_next = fill_reg;
        ptr_next = ptr_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        word0_next = word0_reg;
        hold_next = hold_reg;
        rsp_next = rsp_reg;
        out_valid_next = out_valid_reg && !out_ready;
        we = 1'b0;
        waddr = '0;
        wdata = req_reg.value;
        raddr = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                rsp_next = '0;
                state_next = S_DONE;
                case (req_reg.mode)
                    iate_pkg::MODE_INSERT:
                    begin
                        if (idx_ext > fill_reg)
                        begin
                            rsp_next.status = iate_pkg::ST_RANGE;
                        end
                        else if (fill_reg >= cap_lim)
                        begin
                            rsp_next.status = iate_pkg::ST_FULL;
                        end
                        else if (fill_reg == idx_ext)
                        begin
                            we = 1'b1;
                            waddr = AW'(idx_ext);
                            fill_next = fill_reg + 1'b1;
                        end
                        else
                        begin
                            // Walk down from the top, copying entry p-1 to p.
                            raddr = AW'(fill_reg - 1'b1);
                            ptr_next = fill_reg;
                            state_next = S_MOVEW;
                        end
                    end
                    iate_pkg::MODE_DELETE, iate_pkg::MODE_GET, iate_pkg::MODE_SET:
                    begin
                        if (idx_ext >= fill_reg)
                        begin
                            rsp_next.status = iate_pkg::ST_RANGE;
                        end
                        else if (req_reg.mode == iate_pkg::MODE_SET)
                        begin
                            we = 1'b1;
                            waddr = AW'(idx_ext);
                        end
                        else
                        begin
                            raddr = AW'(idx_ext);
                            ptr_next = idx_ext;
                            state_next = S_RD;
                        end
                    end
                    iate_pkg::MODE_LSEARCH:
                    begin
                        rsp_next.status = iate_pkg::ST_MISS;
                        if (fill_reg != '0)
                        begin
                            raddr = '0;
                            ptr_next = '0;
                            state_next = S_RD;
                        end
                    end
                    iate_pkg::MODE_BSEARCH:
                    begin
                        rsp_next.status = iate_pkg::ST_MISS;
                        lo_next = '0;
                        hi_next = {1'b0, fill_reg} - 1'b1;
                        if (fill_reg != '0)
                        begin
                            raddr = AW'(({1'b0, fill_reg} - 1'b1) >> 1);
                            state_next = S_BWAIT;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_MOVEW:
            begin
                // Insert: rdata is entry ptr-1, goes to ptr.
                we = 1'b1;
                waddr = AW'(ptr_reg);
                wdata = rdata;
                ptr_next = ptr_reg - 1'b1;
                if (ptr_reg - 1'b1 == idx_ext)
                begin
                    state_next = S_SWAP;
                end
                else
                begin
                    raddr = AW'(ptr_reg - 2'd2);
                end
            end
            S_MOVE:
            begin
                // Delete: rdata is entry ptr+1, goes to ptr.
                we = 1'b1;
                waddr = AW'(ptr_reg);
                wdata = rdata;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg + 2'd2 >= fill_reg)
                begin
                    fill_next = fill_reg - 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    raddr = AW'(ptr_reg + 2'd2);
                end
            end
            S_RD:
            begin
                case (req_reg.mode)
                    iate_pkg::MODE_GET:
                    begin
                        rsp_next.data = rdata;
                        state_next = S_DONE;
                    end
                    iate_pkg::MODE_DELETE:
                    begin
                        rsp_next.data = rdata;
                        if (ptr_reg + 1'b1 >= fill_reg)
                        begin
                            fill_next = fill_reg - 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            raddr = AW'(ptr_reg + 1'b1);
                            state_next = S_MOVE;
                        end
                    end
                    default:
                    begin
                        // Linear search: entry ptr is on rdata.
                        if (ptr_reg == '0)
                        begin
                            word0_next = rdata;
                        end
                        if (rdata == req_reg.value)
                        begin
                            rsp_next.status = iate_pkg::ST_OK;
                            rsp_next.position = 6'(ptr_reg);
                            // Entry ptr takes old entry 0; entry 0 takes the key.
                            we = 1'b1;
                            waddr = AW'(ptr_reg);
                            wdata = (ptr_reg == '0) ? rdata : word0_reg;
                            hold_next = rdata;
                            state_next = S_SWAP;
                        end
                        else if (ptr_reg + 1'b1 >= fill_reg)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            raddr = AW'(ptr_reg + 1'b1);
                            ptr_next = ptr_reg + 1'b1;
                        end
                    end
                endcase
            end
            S_SWAP:
            begin
                we = 1'b1;
                state_next = S_DONE;
                if (req_reg.mode == iate_pkg::MODE_INSERT)
                begin
                    waddr = AW'(idx_ext);
                    wdata = req_reg.value;
                    fill_next = fill_reg + 1'b1;
                end
                else
                begin
                    waddr = '0;
                    wdata = hold_reg;
                end
            end
            S_BWAIT:
            begin
                if (rdata == req_reg.value)
                begin
                    rsp_next.status = iate_pkg::ST_OK;
                    rsp_next.position = 6'(mid);
                    state_next = S_DONE;
                end
                else
                begin
                    if ($signed(req_reg.value) < $signed(rdata))
                    begin
                        hi_next = mid - 1'b1;
                        lo_next = lo_reg;
                    end
                    else
                    begin
                        lo_next = mid + 1'b1;
                        hi_next = hi_reg;
                    end
                    // hi may go to -1: the top bit marks it negative.
                    if (hi_next[CW] || lo_next > hi_next)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        raddr = AW'((lo_next + hi_next) >> 1);
                    end
                end
            end
            S_DONE:
            begin
                rsp_next.count = fill_reg;
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg <= '0;
            cap_reg <= 7'd64;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_data;
        end
        ptr_reg <= ptr_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        word0_reg <= word0_next;
        hold_reg <= hold_next;
        rsp_reg <= rsp_next;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(iate_pkg::DEPTH))
        else $error("fill count beyond depth");
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |-> (fill_reg == $past(fill_reg) + 1'b1 ||
                                           fill_reg == $past(fill_reg) - 1'b1))
        else $error("fill count jumped");
    a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> rsp_reg.count == fill_reg)
        else $error("reported count differs from fill");
`endif

endmodule

// ----- tb/sv/tb.sv -----
module tb;

    // Clock, reset and the block's ports.
    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [6:0] cfg_wdata;
    logic in_valid;
    logic in_ready;
    iate_pkg::req_t in_data;
    logic out_valid;
    logic out_ready;
    iate_pkg::rsp_t out_data;

    indexed_array_table_engine uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    localparam int WATCHDOG_LIMIT = 20000;

    // The testbench's own picture of the table: its words, its fill count and
    // the capacity register as last written.
    logic [31:0] shadow_words [0:63];
    int unsigned shadow_fill;
    int unsigned shadow_cap;

    // Results worked out for each accepted item, oldest first.
    iate_pkg::rsp_t pending_results [$];

    int error_count;
    int idle_cycles;
    bit hold_receiver;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Signed comparison of two table words.
    function automatic bit word_below(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // Applies one item to the shadow table and returns the result the block
    // should give for it.
    function automatic iate_pkg::rsp_t table_outcome(iate_pkg::req_t req);
        iate_pkg::rsp_t r;
        int unsigned lim;
        int lo;
        int hi;
        int mid;
        logic [31:0] swap_word;
        r = '0;
        lim = (shadow_cap < 64) ? shadow_cap : 64;
        case (req.mode)
            iate_pkg::MODE_INSERT:
            begin
                if (req.index > shadow_fill)
                    r.status = iate_pkg::ST_RANGE;
                else if (shadow_fill >= lim)
                    r.status = iate_pkg::ST_FULL;
                else
                begin
                    for (int i = shadow_fill; i > req.index; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[req.index] = req.value;
                    shadow_fill++;
                end
            end
            iate_pkg::MODE_DELETE:
            begin
                if (req.index >= shadow_fill)
                    r.status = iate_pkg::ST_RANGE;
                else
                begin
                    r.data = shadow_words[req.index];
                    for (int i = req.index; i + 1 < shadow_fill; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_fill--;
                end
            end
            iate_pkg::MODE_LSEARCH:
            begin
                r.status = iate_pkg::ST_MISS;
                for (int i = 0; i < shadow_fill; i++)
                begin
                    if (shadow_words[i] == req.value)
                    begin
                        swap_word = shadow_words[i];
                        shadow_words[i] = shadow_words[0];
                        shadow_words[0] = swap_word;
                        r.position = 6'(i);
                        r.status = iate_pkg::ST_OK;
                        break;
                    end
                end
            end
            iate_pkg::MODE_BSEARCH:
            begin
                r.status = iate_pkg::ST_MISS;
                lo = 0;
                hi = int'(shadow_fill) - 1;
                while (lo <= hi)
                begin
                    mid = (lo + hi) / 2;
                    if (shadow_words[mid] == req.value)
                    begin
                        r.position = 6'(mid);
                        r.status = iate_pkg::ST_OK;
                        break;
                    end
                    else if (word_below(req.value, shadow_words[mid]))
                        hi = mid - 1;
                    else
                        lo = mid + 1;
                end
            end
            iate_pkg::MODE_GET:
            begin
                if (req.index >= shadow_fill)
                    r.status = iate_pkg::ST_RANGE;
                else
                    r.data = shadow_words[req.index];
            end
            iate_pkg::MODE_SET:
            begin
                if (req.index >= shadow_fill)
                    r.status = iate_pkg::ST_RANGE;
                else
                    shadow_words[req.index] = req.value;
            end
            default:
            begin
            end
        endcase
        r.count = 7'(shadow_fill);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch: %s got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    // Sends one item, after a random gap now and then to break up the bursts.
    // Within a burst valid stays high from one item to the next.
    int burst_left;
    task automatic send_item(logic [2:0] mode, logic [5:0] index, logic [31:0] value);
        iate_pkg::req_t req;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        burst_left--;
        req.mode = mode;
        req.index = index;
        req.value = value;
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // Accepted at this edge; the prediction is made at the same edge.
        pending_results.push_back(table_outcome(req));
    endtask

    // Waits until every expected result has come, then lets the block settle,
    // so that the capacity register may be written safely.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_capacity(logic [6:0] cap);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_cap = cap;
    endtask

    // A random index, biased towards the interesting region near the fill.
    function automatic logic [5:0] pick_index();
        int unsigned choice;
        choice = $urandom_range(0, 9);
        if (choice < 7)
            return 6'($urandom_range(0, shadow_fill));
        return 6'($urandom_range(0, 63));
    endfunction

    // Keys drawn from a small pool so that searches hit often, with the
    // full 32-bit range used now and then.
    function automatic logic [31:0] pick_value();
        int unsigned choice;
        choice = $urandom_range(0, 9);
        if (choice < 5)
            return $urandom_range(0, 15) - 8;
        if (choice < 7 && shadow_fill > 0)
            return shadow_words[$urandom_range(0, shadow_fill - 1)];
        return $urandom();
    endfunction

    task automatic test_directed();
        // Search on an empty table, out-of-range accesses and unused modes.
        send_item(iate_pkg::MODE_LSEARCH, 6'd0, 32'd5);
        send_item(iate_pkg::MODE_BSEARCH, 6'd0, 32'd5);
        send_item(iate_pkg::MODE_GET, 6'd0, 32'd0);
        send_item(iate_pkg::MODE_DELETE, 6'd0, 32'd0);
        send_item(iate_pkg::MODE_SET, 6'd0, 32'd1);
        send_item(iate_pkg::MODE_INSERT, 6'd1, 32'd1);
        send_item(3'd6, 6'd63, 32'hFFFFFFFF);
        send_item(3'd7, 6'd0, 32'd0);
        // Extremes of the word, inserted in sorted order.
        send_item(iate_pkg::MODE_INSERT, 6'd0, 32'h7FFFFFFF);
        send_item(iate_pkg::MODE_INSERT, 6'd0, 32'h80000000);
        send_item(iate_pkg::MODE_INSERT, 6'd1, 32'd0);
        send_item(iate_pkg::MODE_BSEARCH, 6'd0, 32'h80000000);
        send_item(iate_pkg::MODE_BSEARCH, 6'd0, 32'h7FFFFFFF);
        send_item(iate_pkg::MODE_BSEARCH, 6'd0, 32'd3);
        send_item(iate_pkg::MODE_LSEARCH, 6'd0, 32'h7FFFFFFF);
        send_item(iate_pkg::MODE_GET, 6'd2, 32'd0);
        send_item(iate_pkg::MODE_SET, 6'd2, 32'h55AA55AA);
        send_item(iate_pkg::MODE_GET, 6'd63, 32'd0);
        send_item(iate_pkg::MODE_DELETE, 6'd1, 32'd0);
        send_item(iate_pkg::MODE_INSERT, 6'd3, 32'd9);
    endtask

    // Fills the table to the top at full capacity, then reports full.
    task automatic test_fill_to_capacity();
        write_capacity(7'd64);
        while (shadow_fill < 64)
            send_item(iate_pkg::MODE_INSERT, 6'($urandom_range(0, shadow_fill)),
                      $urandom());
        send_item(iate_pkg::MODE_INSERT, 6'd0, 32'd1);
        send_item(iate_pkg::MODE_INSERT, 6'd63, 32'd1);
        send_item(iate_pkg::MODE_LSEARCH, 6'd0, shadow_words[63]);
        send_item(iate_pkg::MODE_DELETE, 6'd63, 32'd0);
        send_item(iate_pkg::MODE_GET, 6'd62, 32'd0);
    endtask

    // Capacity lowered below the fill, to zero, and above the storage depth.
    task automatic test_capacity_limits();
        write_capacity(7'd3);
        send_item(iate_pkg::MODE_INSERT, 6'd0, 32'd4);
        send_item(iate_pkg::MODE_GET, 6'd10, 32'd0);
        while (shadow_fill > 0)
            send_item(iate_pkg::MODE_DELETE, 6'($urandom_range(0, shadow_fill - 1)),
                      32'd0);
        write_capacity(7'd0);
        send_item(iate_pkg::MODE_INSERT, 6'd0, 32'd4);
        write_capacity(7'd1);
        send_item(iate_pkg::MODE_INSERT, 6'd0, 32'd4);
        send_item(iate_pkg::MODE_INSERT, 6'd0, 32'd5);
        write_capacity(7'd127);
    endtask

    // Random traffic in phases, each setting a capacity from a list of six. Sorted
    // (odd) phases put inserts in their sorted place so binary search can hit.
    task automatic test_random_phases();
        logic [6:0] caps [6];
        logic [31:0] v;
        int unsigned mode_pick;
        int unsigned pos;
        caps = '{7'd64, 7'd8, 7'd1, 7'd100, 7'd33, 7'd2};
        for (int phase = 0; phase < 12; phase++)
        begin
            write_capacity(caps[phase % 6]);
            if (phase == 5)
            begin
                // Sender holds off until every expected result is back.
                drain_results();
            end
            for (int n = 0; n < 110; n++)
            begin
                mode_pick = $urandom_range(0, 99);
                if (phase % 2 == 1 && mode_pick < 40)
                begin
                    // Sorted insert: find the place for the new word.
                    v = pick_value();
                    pos = 0;
                    while (pos < shadow_fill && word_below(shadow_words[pos], v))
                        pos++;
                    send_item(iate_pkg::MODE_INSERT, 6'(pos), v);
                end
                else if (phase % 2 == 1 && mode_pick < 60)
                    send_item(iate_pkg::MODE_BSEARCH, pick_index(), pick_value());
                else if (mode_pick < 30)
                    send_item(iate_pkg::MODE_INSERT, pick_index(), pick_value());
                else if (mode_pick < 50)
                    send_item(iate_pkg::MODE_DELETE, pick_index(), pick_value());
                else if (mode_pick < 65)
                    send_item(iate_pkg::MODE_LSEARCH, pick_index(), pick_value());
                else if (mode_pick < 75)
                    send_item(iate_pkg::MODE_BSEARCH, pick_index(), pick_value());
                else if (mode_pick < 85)
                    send_item(iate_pkg::MODE_GET, pick_index(), pick_value());
                else if (mode_pick < 97 && phase % 2 == 0)
                    send_item(iate_pkg::MODE_SET, pick_index(), pick_value());
                else
                    send_item(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                              $urandom());
            end
            if (phase % 2 == 0)
            begin
                // Leave the table empty so the next sorted phase starts sorted.
                while (shadow_fill > 0)
                    send_item(iate_pkg::MODE_DELETE,
                              6'($urandom_range(0, shadow_fill - 1)), 32'd0);
            end
        end
    endtask

    // The receiver stalls in a pattern of its own, with long stretches of none.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_receiver)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 60) == 0)
                hold_receiver = ~hold_receiver;
        end
    end

    // Compares each accepted result, field by field, with the oldest expected.
    initial
    begin
        iate_pkg::rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result", out_data.data, 32'd0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.data !== want.data)
                        report_mismatch("data", out_data.data, want.data);
                    if (out_data.position !== want.position)
                        report_mismatch("position", 32'(out_data.position),
                                        32'(want.position));
                    if (out_data.status !== want.status)
                        report_mismatch("status", 32'(out_data.status),
                                        32'(want.status));
                    if (out_data.count !== want.count)
                        report_mismatch("count", 32'(out_data.count),
                                        32'(want.count));
                end
            end
        end
    end

    // Watchdog: ends the run when nothing is accepted on either side for too long.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d results outstanding",
                         pending_results.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        in_data = '0;
        error_count = 0;
        burst_left = 0;
        hold_receiver = 1'b0;
        shadow_fill = 0;
        shadow_cap = 64;
        for (int i = 0; i < 64; i++)
            shadow_words[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_to_capacity();
        test_capacity_limits();
        test_random_phases();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/iate_pkg.sv
rtl/iate_ram.sv
rtl/indexed_array_table_engine.sv
tb/sv/tb.sv
